// ===== hw/rtl/clp_pkg.sv =====
// ----------------------------------------------------------------------------
// clp_pkg
// Shared types and constants for the C literal to number parser.
// ----------------------------------------------------------------------------
package clp_pkg;

   localparam int unsigned CHAR_W  = 8;
   localparam int unsigned VALUE_W = 64;

   // Where the parser stands within the current literal.
   typedef enum logic [3:0] {
      MODE_START  = 4'd0,
      MODE_DEC    = 4'd1,
      MODE_PEND   = 4'd2,
      MODE_HEX    = 4'd3,
      MODE_OCT    = 4'd4,
      MODE_QUOTE  = 4'd5,
      MODE_ESC    = 4'd6,
      MODE_ESCOCT = 4'd7,
      MODE_ESCHEX = 4'd8,
      MODE_DONE   = 4'd9
   } mode_type;

   // Parser state carried from one byte to the next.
   typedef struct packed {
      mode_type               mode;
      logic [VALUE_W-1:0]     acc;
      logic [CHAR_W-1:0]      first;
   } state_type;

   // Character codes the parser reacts to.
   localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;  // '0'
   localparam logic [CHAR_W-1:0] CH_ONE    = 8'h31;  // '1'
   localparam logic [CHAR_W-1:0] CH_SEVEN  = 8'h37;  // '7'
   localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;  // '9'
   localparam logic [CHAR_W-1:0] CH_UP_A   = 8'h41;  // 'A'
   localparam logic [CHAR_W-1:0] CH_UP_F   = 8'h46;  // 'F'
   localparam logic [CHAR_W-1:0] CH_LO_A   = 8'h61;  // 'a'
   localparam logic [CHAR_W-1:0] CH_LO_F   = 8'h66;  // 'f'
   localparam logic [CHAR_W-1:0] CH_UP_X   = 8'h58;  // 'X'
   localparam logic [CHAR_W-1:0] CH_LO_X   = 8'h78;  // 'x'
   localparam logic [CHAR_W-1:0] CH_QUOTE  = 8'h27;  // single quote
   localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'h22;  // double quote
   localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;  // backslash
   localparam logic [CHAR_W-1:0] CH_QMARK  = 8'h3F;  // question mark
   localparam logic [CHAR_W-1:0] CH_LO_N   = 8'h6E;  // 'n'
   localparam logic [CHAR_W-1:0] CH_LO_T   = 8'h74;  // 't'
   localparam logic [CHAR_W-1:0] CH_LO_V   = 8'h76;  // 'v'
   localparam logic [CHAR_W-1:0] CH_LO_R   = 8'h72;  // 'r'

   // Values of the named escapes.
   localparam logic [VALUE_W-1:0] ESC_BSLASH = 64'd92;
   localparam logic [VALUE_W-1:0] ESC_NL     = 64'd10;
   localparam logic [VALUE_W-1:0] ESC_TAB    = 64'd9;
   localparam logic [VALUE_W-1:0] ESC_VTAB   = 64'd11;
   localparam logic [VALUE_W-1:0] ESC_CR     = 64'd13;
   localparam logic [VALUE_W-1:0] ESC_QUOTE  = 64'd39;
   localparam logic [VALUE_W-1:0] ESC_DQUOTE = 64'd34;
   localparam logic [VALUE_W-1:0] ESC_QMARK  = 64'd63;

endpackage

// ===== hw/rtl/clp_step.sv =====
// ----------------------------------------------------------------------------
// clp_step
// One parser step: next state and the literal's value if this byte ends it.
// ----------------------------------------------------------------------------
module clp_step (
   input  clp_pkg::state_type              cur,
   input  logic [clp_pkg::CHAR_W-1:0]      ch,
   output clp_pkg::state_type              nxt,
   output logic [clp_pkg::VALUE_W-1:0]     value
);

   logic                            is_oct;
   logic                            is_dec;
   logic                            is_hex;
   logic [3:0]                      hex_val;
   logic [clp_pkg::VALUE_W-1:0]     digit;
   logic                            first_oct;
   logic [clp_pkg::VALUE_W-1:0]     first_digit;
   logic [clp_pkg::VALUE_W-1:0]     acc_x8;
   logic [clp_pkg::VALUE_W-1:0]     acc_x10;
   logic [clp_pkg::VALUE_W-1:0]     acc_x16;

   assign is_oct = (ch >= clp_pkg::CH_ZERO) && (ch <= clp_pkg::CH_SEVEN);
   assign is_dec = (ch >= clp_pkg::CH_ZERO) && (ch <= clp_pkg::CH_NINE);
   assign digit  = clp_pkg::VALUE_W'(ch[3:0]);

   assign first_oct   = (cur.first >= clp_pkg::CH_ZERO) && (cur.first <= clp_pkg::CH_SEVEN);
   assign first_digit = clp_pkg::VALUE_W'(cur.first[2:0]);

   // Hex digit decode; letters map to 10..15 from their low three bits.
   always_comb begin
      is_hex  = 1'b1;
      hex_val = ch[3:0];
      if (is_dec) begin
         hex_val = ch[3:0];
      end else if (((ch >= clp_pkg::CH_UP_A) && (ch <= clp_pkg::CH_UP_F)) ||
                   ((ch >= clp_pkg::CH_LO_A) && (ch <= clp_pkg::CH_LO_F))) begin
         hex_val = 4'(ch[2:0] + 3'd1) + 4'd8;
      end else begin
         is_hex  = 1'b0;
      end
   end

   assign acc_x8  = {cur.acc[clp_pkg::VALUE_W-4:0], 3'b000};
   assign acc_x16 = {cur.acc[clp_pkg::VALUE_W-5:0], 4'b0000};
   assign acc_x10 = acc_x8 + {cur.acc[clp_pkg::VALUE_W-2:0], 1'b0};

   always_comb begin
      nxt = cur;
      unique case (cur.mode)
         clp_pkg::MODE_START: begin
            if (ch == clp_pkg::CH_QUOTE) begin
               nxt.mode = clp_pkg::MODE_QUOTE;
            end else if ((ch >= clp_pkg::CH_ONE) && (ch <= clp_pkg::CH_NINE)) begin
               nxt.acc  = digit;
               nxt.mode = clp_pkg::MODE_DEC;
            end else begin
               nxt.first = ch;
               nxt.mode  = clp_pkg::MODE_PEND;
            end
         end
         clp_pkg::MODE_DEC: begin
            if (is_dec) begin
               nxt.acc = acc_x10 + digit;
            end else begin
               nxt.mode = clp_pkg::MODE_DONE;
            end
         end
         clp_pkg::MODE_PEND: begin
            // Second byte decides hex; else octal from leading octal bytes.
            if ((ch == clp_pkg::CH_LO_X) || (ch == clp_pkg::CH_UP_X)) begin
               nxt.mode = clp_pkg::MODE_HEX;
            end else if (!first_oct) begin
               nxt.mode = clp_pkg::MODE_DONE;
            end else if (is_oct) begin
               nxt.acc  = {first_digit[clp_pkg::VALUE_W-4:0], 3'b000} + digit;
               nxt.mode = clp_pkg::MODE_OCT;
            end else begin
               nxt.acc  = first_digit;
               nxt.mode = clp_pkg::MODE_DONE;
            end
         end
         clp_pkg::MODE_HEX, clp_pkg::MODE_ESCHEX: begin
            if (is_hex) begin
               nxt.acc = acc_x16 + clp_pkg::VALUE_W'(hex_val);
            end else begin
               nxt.mode = clp_pkg::MODE_DONE;
            end
         end
         clp_pkg::MODE_OCT, clp_pkg::MODE_ESCOCT: begin
            if (is_oct) begin
               nxt.acc = acc_x8 + digit;
            end else begin
               nxt.mode = clp_pkg::MODE_DONE;
            end
         end
         clp_pkg::MODE_QUOTE: begin
            if (ch == clp_pkg::CH_BSLASH) begin
               nxt.mode = clp_pkg::MODE_ESC;
            end else begin
               nxt.acc  = clp_pkg::VALUE_W'(ch);
               nxt.mode = clp_pkg::MODE_DONE;
            end
         end
         clp_pkg::MODE_ESC: begin
            nxt.mode = clp_pkg::MODE_DONE;
            unique case (ch)
               clp_pkg::CH_BSLASH: nxt.acc = clp_pkg::ESC_BSLASH;
               clp_pkg::CH_LO_N:   nxt.acc = clp_pkg::ESC_NL;
               clp_pkg::CH_LO_T:   nxt.acc = clp_pkg::ESC_TAB;
               clp_pkg::CH_LO_V:   nxt.acc = clp_pkg::ESC_VTAB;
               clp_pkg::CH_LO_R:   nxt.acc = clp_pkg::ESC_CR;
               clp_pkg::CH_QUOTE:  nxt.acc = clp_pkg::ESC_QUOTE;
               clp_pkg::CH_DQUOTE: nxt.acc = clp_pkg::ESC_DQUOTE;
               clp_pkg::CH_QMARK:  nxt.acc = clp_pkg::ESC_QMARK;
               clp_pkg::CH_LO_X:   nxt.mode = clp_pkg::MODE_ESCHEX;
               default: begin
                  if (is_oct) begin
                     nxt.acc  = digit;
                     nxt.mode = clp_pkg::MODE_ESCOCT;
                  end else begin
                     nxt.acc  = clp_pkg::ESC_BSLASH;
                  end
               end
            endcase
         end
         default: begin
            nxt.mode = clp_pkg::MODE_DONE;
         end
      endcase
   end

   // Value if the literal ends on this byte.
   always_comb begin
      if (nxt.mode == clp_pkg::MODE_ESC) begin
         value = clp_pkg::ESC_BSLASH;
      end else if (nxt.mode == clp_pkg::MODE_PEND) begin
         // Lone first byte: one octal digit or nothing.
         if ((nxt.first >= clp_pkg::CH_ZERO) && (nxt.first <= clp_pkg::CH_SEVEN)) begin
            value = clp_pkg::VALUE_W'(nxt.first[2:0]);
         end else begin
            value = '0;
         end
      end else begin
         value = nxt.acc;
      end
   end

endmodule

// ===== hw/rtl/c_literal_to_number_top.sv =====
// ----------------------------------------------------------------------------
// c_literal_to_number_top
// Streaming parser of C integer and character literals into 64-bit values.
// ----------------------------------------------------------------------------
// Feed one literal's text one byte per transaction on the req_ channel, with
// req_tlast high on its final byte; the literal's value, wrapped modulo 2^64,
// comes out as one transaction on the rsp_ channel and the parser is then
// ready for the next literal. A leading 1-9 reads decimal, a first byte
// followed by x or X reads hex, a leading quote reads a character literal
// with escapes, anything else reads octal; parsing stops at the first byte
// that fits no digit class and the rest of the literal is skipped. The
// block takes one byte every clock cycle, back to back, except while a last
// byte is held back as below; the per-byte shift-add step lies between the
// input register and the parser state. An accepted byte is held in the
// input register, then steps the parser; a last byte's value is loaded into
// the result register and offered on rsp_ from there. A last byte waits in
// the input register while the result register is full and not being
// drained, which stalls req_ until rsp_ takes the value.
// ----------------------------------------------------------------------------
module c_literal_to_number_top (
   input  logic                           clock,
   input  logic                           reset,

   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [clp_pkg::CHAR_W-1:0]     req_tdata,   // [7:0] ch
   input  logic                           req_tlast,   // last byte of the literal

   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [clp_pkg::VALUE_W-1:0]    rsp_tdata    // [63:0] value
);

   // Input register.
   logic                            in_valid_ff;
   logic                            in_valid_in;
   logic [clp_pkg::CHAR_W-1:0]      in_ch_ff;
   logic                            in_last_ff;

   // Parser state.
   clp_pkg::state_type              state_ff;
   clp_pkg::state_type              state_in;
   clp_pkg::state_type              step_nxt;
   logic [clp_pkg::VALUE_W-1:0]     step_value;

   // Result register.
   logic                            out_valid_ff;
   logic                            out_valid_in;
   logic [clp_pkg::VALUE_W-1:0]     out_value_ff;

   logic                            out_free;
   logic                            advance;
   logic                            load_result;

   clp_step u_step (
      .cur   (state_ff),
      .ch    (in_ch_ff),
      .nxt   (step_nxt),
      .value (step_value)
   );

   // The result register can take a value when empty or being drained.
   assign out_free    = !out_valid_ff || rsp_tready;
   // A held byte moves into the parser unless it ends a literal whose
   // result has nowhere to go yet.
   assign advance     = in_valid_ff && (!in_last_ff || out_free);
   assign load_result = advance && in_last_ff;
   assign req_tready  = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      state_in = state_ff;
      if (load_result) begin
         // Return to the start of a literal.
         state_in.mode  = clp_pkg::MODE_START;
         state_in.acc   = '0;
         state_in.first = '0;
      end else if (advance) begin
         state_in = step_nxt;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (load_result) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         state_ff.mode  <= clp_pkg::MODE_START;
         state_ff.acc   <= '0;
         state_ff.first <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   // Payload registers: capture on transaction, hold otherwise.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_ch_ff   <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (load_result) begin
         out_value_ff <= step_value;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_value_ff;

endmodule

// ===== tb/clp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clp_checker
// Watches both streams of the literal parser, predicts every value and
// compares it with what comes out.
// ----------------------------------------------------------------------------
module clp_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   input  logic                        req_tready,
   input  logic [clp_pkg::CHAR_W-1:0]  req_tdata,
   input  logic                        req_tlast,
   input  logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   input  logic [clp_pkg::VALUE_W-1:0] rsp_tdata,
   output int                          errors,
   output int                          pending,
   output int                          checked
);

   localparam clp_pkg::state_type IDLE_STATE =
      '{mode: clp_pkg::MODE_START, acc: '0, first: '0};

   clp_pkg::state_type          parse_state;
   logic [clp_pkg::VALUE_W-1:0] values_due[$];
   int                          err_n;
   int                          seen_n;

   function automatic logic is_octal(logic [clp_pkg::CHAR_W-1:0] c);
      return c >= clp_pkg::CH_ZERO && c <= clp_pkg::CH_SEVEN;
   endfunction

   // Advance the parse by one byte of literal text.
   function automatic clp_pkg::state_type parse_step(clp_pkg::state_type s,
                                                     logic [clp_pkg::CHAR_W-1:0] c);
      clp_pkg::state_type          n;
      logic [clp_pkg::VALUE_W-1:0] dig;
      logic [clp_pkg::VALUE_W-1:0] nib;
      logic                        hex_ok;
      n      = s;
      dig    = {56'd0, c - clp_pkg::CH_ZERO};
      hex_ok = 1'b1;
      if (c >= clp_pkg::CH_ZERO && c <= clp_pkg::CH_NINE) begin
         nib = dig;
      end else if (c >= clp_pkg::CH_UP_A && c <= clp_pkg::CH_UP_F) begin
         nib = {56'd0, c - clp_pkg::CH_UP_A} + 64'd10;
      end else if (c >= clp_pkg::CH_LO_A && c <= clp_pkg::CH_LO_F) begin
         nib = {56'd0, c - clp_pkg::CH_LO_A} + 64'd10;
      end else begin
         nib    = '0;
         hex_ok = 1'b0;
      end
      case (s.mode)
         clp_pkg::MODE_START: begin
            if (c == clp_pkg::CH_QUOTE) begin
               n.mode = clp_pkg::MODE_QUOTE;
            end else if (c >= clp_pkg::CH_ONE && c <= clp_pkg::CH_NINE) begin
               n.acc  = dig;
               n.mode = clp_pkg::MODE_DEC;
            end else begin
               n.first = c;
               n.mode  = clp_pkg::MODE_PEND;
            end
         end
         clp_pkg::MODE_DEC: begin
            if (c >= clp_pkg::CH_ZERO && c <= clp_pkg::CH_NINE) n.acc = s.acc * 64'd10 + dig;
            else n.mode = clp_pkg::MODE_DONE;
         end
         clp_pkg::MODE_PEND: begin
            // second byte decides between a hex prefix and plain octal
            if (c == clp_pkg::CH_LO_X || c == clp_pkg::CH_UP_X) begin
               n.mode = clp_pkg::MODE_HEX;
            end else if (!is_octal(s.first)) begin
               n.mode = clp_pkg::MODE_DONE;
            end else begin
               n.acc = (s.acc << 3) + {56'd0, s.first - clp_pkg::CH_ZERO};
               if (is_octal(c)) begin
                  n.acc  = (n.acc << 3) + dig;
                  n.mode = clp_pkg::MODE_OCT;
               end else begin
                  n.mode = clp_pkg::MODE_DONE;
               end
            end
         end
         clp_pkg::MODE_HEX, clp_pkg::MODE_ESCHEX: begin
            if (hex_ok) n.acc = (s.acc << 4) + nib;
            else n.mode = clp_pkg::MODE_DONE;
         end
         clp_pkg::MODE_OCT, clp_pkg::MODE_ESCOCT: begin
            if (is_octal(c)) n.acc = (s.acc << 3) + dig;
            else n.mode = clp_pkg::MODE_DONE;
         end
         clp_pkg::MODE_QUOTE: begin
            if (c == clp_pkg::CH_BSLASH) begin
               n.mode = clp_pkg::MODE_ESC;
            end else begin
               n.acc  = {56'd0, c};
               n.mode = clp_pkg::MODE_DONE;
            end
         end
         clp_pkg::MODE_ESC: begin
            n.mode = clp_pkg::MODE_DONE;
            case (c)
               clp_pkg::CH_BSLASH: n.acc = clp_pkg::ESC_BSLASH;
               clp_pkg::CH_LO_N:   n.acc = clp_pkg::ESC_NL;
               clp_pkg::CH_LO_T:   n.acc = clp_pkg::ESC_TAB;
               clp_pkg::CH_LO_V:   n.acc = clp_pkg::ESC_VTAB;
               clp_pkg::CH_LO_R:   n.acc = clp_pkg::ESC_CR;
               clp_pkg::CH_QUOTE:  n.acc = clp_pkg::ESC_QUOTE;
               clp_pkg::CH_DQUOTE: n.acc = clp_pkg::ESC_DQUOTE;
               clp_pkg::CH_QMARK:  n.acc = clp_pkg::ESC_QMARK;
               clp_pkg::CH_LO_X:   n.mode = clp_pkg::MODE_ESCHEX;
               default: begin
                  if (is_octal(c)) begin
                     n.acc  = dig;
                     n.mode = clp_pkg::MODE_ESCOCT;
                  end else begin
                     n.acc = clp_pkg::ESC_BSLASH;
                  end
               end
            endcase
         end
         default: n.mode = clp_pkg::MODE_DONE;
      endcase
      return n;
   endfunction

   // Value a literal yields when its text ends in state s.
   function automatic logic [clp_pkg::VALUE_W-1:0] literal_value(clp_pkg::state_type s);
      case (s.mode)
         clp_pkg::MODE_ESC:  return clp_pkg::ESC_BSLASH;
         clp_pkg::MODE_PEND: return is_octal(s.first) ?
                                    {56'd0, s.first - clp_pkg::CH_ZERO} : '0;
         default:            return s.acc;
      endcase
   endfunction

   always @(posedge clock) begin : watch
      logic [clp_pkg::VALUE_W-1:0] want;
      if (reset) begin
         parse_state = IDLE_STATE;
         values_due.delete();
         err_n  = 0;
         seen_n = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (values_due.size() == 0) begin
               err_n++;
               $display("%0t clp_checker: unexpected value, expected none, actual %h",
                        $time, rsp_tdata);
            end else begin
               want = values_due.pop_front();
               seen_n++;
               if (rsp_tdata !== want) begin
                  err_n++;
                  $display("%0t clp_checker: value mismatch, expected %h, actual %h",
                           $time, want, rsp_tdata);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            parse_state = parse_step(parse_state, req_tdata);
            if (req_tlast) begin
               values_due.push_back(literal_value(parse_state));
               parse_state = IDLE_STATE;
            end
         end
      end
      errors  <= err_n;
      pending <= values_due.size();
      checked <= seen_n;
   end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stream test of the C literal to number parser.
// ----------------------------------------------------------------------------
// Sends a short run of hand-picked corner literals, then random decimal, hex,
// octal and character literals (plus raw noise) one byte per transaction,
// with random gaps on the input and random stalls on the output. A separate
// checker predicts every value and compares; this module only makes traffic
// and gives the verdict.
// ----------------------------------------------------------------------------
module tb;

   localparam int ITEM_TARGET = 1750;
   localparam int CYCLE_LIMIT = 400000;
   localparam int LONG_HOLD   = 300;
   localparam int DRAIN       = 10;

   typedef enum int {LIT_DEC, LIT_HEX, LIT_OCT, LIT_CHAR, LIT_NOISE, LIT_KINDS} lit_kind_type;

   // escape letters with a fixed meaning
   localparam logic [clp_pkg::CHAR_W-1:0] NAMED_ESC[8] = '{
      clp_pkg::CH_BSLASH, clp_pkg::CH_LO_N, clp_pkg::CH_LO_T, clp_pkg::CH_LO_V,
      clp_pkg::CH_LO_R, clp_pkg::CH_QUOTE, clp_pkg::CH_DQUOTE, clp_pkg::CH_QMARK};

   logic                        clock      = 1'b0;
   logic                        reset      = 1'b1;
   logic                        req_tvalid = 1'b0;
   logic                        req_tready;
   logic [clp_pkg::CHAR_W-1:0]  req_tdata  = '0;
   logic                        req_tlast  = 1'b0;
   logic                        rsp_tvalid;
   logic                        rsp_tready = 1'b0;
   logic [clp_pkg::VALUE_W-1:0] rsp_tdata;

   int errors;
   int pending;
   int checked;
   int cycles      = 0;
   int holds_asked = 0;
   int holds_done  = 0;
   int bytes_sent  = 0;
   int lits_sent   = 0;
   int useful_sent = 0;
   int kind_count[LIT_KINDS];

   logic [clp_pkg::CHAR_W-1:0] lit_bytes[$];
   int                         lit_useful;
   bit                         send_burst = 1'b0;
   bit                         take_burst = 1'b0;

   always #5 clock = ~clock;

   always @(posedge clock) cycles <= cycles + 1;

   c_literal_to_number_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   clp_checker value_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .errors     (errors),
      .pending    (pending),
      .checked    (checked)
   );

   // Draw one digit character of the given class.
   function automatic logic [clp_pkg::CHAR_W-1:0] digit_char(lit_kind_type k);
      logic [clp_pkg::CHAR_W-1:0] d;
      case (k)
         LIT_OCT: d = clp_pkg::CH_ZERO + 8'($urandom_range(0, 7));
         LIT_HEX: begin
            case ($urandom_range(0, 2))
               0:       d = clp_pkg::CH_ZERO + 8'($urandom_range(0, 9));
               1:       d = clp_pkg::CH_UP_A + 8'($urandom_range(0, 5));
               default: d = clp_pkg::CH_LO_A + 8'($urandom_range(0, 5));
            endcase
         end
         default: d = clp_pkg::CH_ZERO + 8'($urandom_range(0, 9));
      endcase
      return d;
   endfunction

   task automatic push_digits(int count, lit_kind_type k);
      for (int i = 0; i < count; i++) lit_bytes.push_back(digit_char(k));
   endtask

   // Fill lit_bytes with one random literal of kind k. Long digit strings
   // are kept in reach so the 64-bit wrap gets exercised.
   task automatic build_literal(lit_kind_type k);
      bit junk;
      lit_bytes.delete();
      case (k)
         LIT_DEC: begin
            lit_bytes.push_back(clp_pkg::CH_ONE + 8'($urandom_range(0, 8)));
            push_digits($urandom_range(0, 24), LIT_DEC);
         end
         LIT_HEX: begin
            // the byte ahead of the x need not be a zero
            lit_bytes.push_back($urandom_range(0, 3) == 0 ? 8'($urandom) : clp_pkg::CH_ZERO);
            lit_bytes.push_back($urandom_range(0, 1) ? clp_pkg::CH_LO_X : clp_pkg::CH_UP_X);
            push_digits($urandom_range(0, 17), LIT_HEX);
         end
         LIT_OCT: begin
            lit_bytes.push_back($urandom_range(0, 7) == 0 ? 8'($urandom) : clp_pkg::CH_ZERO);
            push_digits($urandom_range(0, 23), LIT_OCT);
         end
         LIT_CHAR: begin
            lit_bytes.push_back(clp_pkg::CH_QUOTE);
            case ($urandom_range(0, 4))
               0: lit_bytes.push_back(8'($urandom));
               1: begin
                  lit_bytes.push_back(clp_pkg::CH_BSLASH);
                  lit_bytes.push_back(NAMED_ESC[$urandom_range(0, 7)]);
               end
               2: begin
                  lit_bytes.push_back(clp_pkg::CH_BSLASH);
                  push_digits($urandom_range(0, 3) == 0 ? $urandom_range(1, 24)
                                                        : $urandom_range(1, 3), LIT_OCT);
               end
               3: begin
                  lit_bytes.push_back(clp_pkg::CH_BSLASH);
                  lit_bytes.push_back(clp_pkg::CH_LO_X);
                  push_digits($urandom_range(0, 17), LIT_HEX);
               end
               default: begin
                  lit_bytes.push_back(clp_pkg::CH_BSLASH);
                  lit_bytes.push_back(8'($urandom));
               end
            endcase
         end
         default: repeat ($urandom_range(1, 6)) lit_bytes.push_back(8'($urandom));
      endcase
      // a stray byte usually stops the parse; what follows it is skipped
      junk       = ($urandom_range(0, 3) == 0);
      lit_useful = lit_bytes.size() + (junk ? 1 : 0);
      if (junk) repeat ($urandom_range(1, 4)) lit_bytes.push_back(8'($urandom));
   endtask

   // Offer one byte after a random gap and hold it until the transaction
   // completes.
   task automatic send_byte(logic [clp_pkg::CHAR_W-1:0] c, logic fin);
      int gap;
      gap = send_burst ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= fin;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
   endtask

   task automatic send_literal();
      for (int i = 0; i < lit_bytes.size(); i++) begin
         send_byte(lit_bytes[i], i == lit_bytes.size() - 1);
      end
      lits_sent++;
   endtask

   // Input side: reset, corner literals, random literals, then drain.
   initial begin : input_side
      lit_kind_type k;
      int           pick;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // lone bytes: zero byte, an octal digit, a decimal digit
      lit_bytes = {8'h00};                                        send_literal();
      lit_bytes = {clp_pkg::CH_SEVEN};                            send_literal();
      lit_bytes = {clp_pkg::CH_NINE};                             send_literal();
      // hex prefix alone, then upper prefix with one digit
      lit_bytes = {clp_pkg::CH_ZERO, clp_pkg::CH_LO_X};           send_literal();
      lit_bytes = {clp_pkg::CH_ZERO, clp_pkg::CH_UP_X, clp_pkg::CH_LO_F};
      send_literal();
      // text ends right after the quote, then right after the backslash
      lit_bytes = {clp_pkg::CH_QUOTE};                            send_literal();
      lit_bytes = {clp_pkg::CH_QUOTE, clp_pkg::CH_BSLASH};        send_literal();
      // unknown escapes: uppercase X and a zero byte
      lit_bytes = {clp_pkg::CH_QUOTE, clp_pkg::CH_BSLASH, clp_pkg::CH_UP_X};
      send_literal();
      lit_bytes = {clp_pkg::CH_QUOTE, clp_pkg::CH_BSLASH, 8'h00}; send_literal();
      // x escape with no digits
      lit_bytes = {clp_pkg::CH_QUOTE, clp_pkg::CH_BSLASH, clp_pkg::CH_LO_X};
      send_literal();
      // top byte as a plain char, taken unsigned
      lit_bytes = {clp_pkg::CH_QUOTE, 8'hFF};                     send_literal();
      // decimal stopped by a letter; the trailing digit is ignored
      lit_bytes = {clp_pkg::CH_ONE, clp_pkg::CH_LO_A, clp_pkg::CH_NINE};
      send_literal();

      while (useful_sent < ITEM_TARGET) begin
         // flip between gappy and back-to-back stretches
         if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
         pick = $urandom_range(0, 9);
         k = pick < 2 ? LIT_DEC : pick < 4 ? LIT_HEX : pick < 6 ? LIT_OCT :
             pick < 9 ? LIT_CHAR : LIT_NOISE;
         build_literal(k);
         kind_count[k]++;
         send_literal();
         useful_sent += lit_useful;
         // ask the output side for a long hold while input keeps coming
         if (lits_sent == 60 || lits_sent == 400) holds_asked <= holds_asked + 1;
      end
      req_tvalid <= 1'b0;

      // let the checker see the final push before polling it
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);

      $display("summary: %0d bytes in %0d literals", bytes_sent, lits_sent);
      $display("summary: dec %0d, hex %0d, oct %0d, char %0d, noise %0d",
               kind_count[LIT_DEC], kind_count[LIT_HEX], kind_count[LIT_OCT],
               kind_count[LIT_CHAR], kind_count[LIT_NOISE]);
      $display("summary: %0d values compared, %0d long output holds", checked, holds_done);
      if (errors == 0 && pending == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

   // Output side: random stalls, burst stretches and the long holds.
   initial begin : output_side
      int stall;
      while (reset) @(posedge clock);
      forever begin
         if (holds_asked > holds_done) begin
            // hold off long enough for the parser to back up its input
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            holds_done++;
         end
         if ($urandom_range(0, 39) == 0) take_burst = !take_burst;
         stall = take_burst ? 0 : $urandom_range(0, 15);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Watchdog: drop the run if it hangs.
   initial begin : watchdog
      wait (cycles >= CYCLE_LIMIT);
      $display("timeout after %0d cycles, %0d values still due", cycles, pending);
      $display("tb: done, errors");
      $finish;
   end

endmodule
